// ===== design/square_tone_burst_with_fade_defines.svh =====
// ----------------------------------------------------------------------------
// square_tone_burst_with_fade_defines.svh
// Assertion macros for the tone burst top-level design file.
// ----------------------------------------------------------------------------
`ifndef SQUARE_TONE_BURST_WITH_FADE_DEFINES_SVH
`define SQUARE_TONE_BURST_WITH_FADE_DEFINES_SVH

// plain property, sampled on clk_i, off during reset
`define STBF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication form
`define STBF_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication form
`define STBF_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/stbf_pkg.sv =====
// ----------------------------------------------------------------------------
// stbf_pkg
// Types and constants of the square tone burst generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stbf_pkg;

  localparam int unsigned DividendW = 32;
  localparam int unsigned DivisorW  = 24;
  localparam int unsigned StepCntW  = $clog2(DividendW);

  localparam int unsigned AmpW   = 15;
  localparam int unsigned PerW   = 24;
  localparam int unsigned PosW   = 20;
  localparam int unsigned FadeW  = 16;
  localparam int unsigned BudW   = 7;
  localparam int unsigned SmpW   = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] REG_AMPLITUDE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_PERIOD    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_TOTAL     = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_FADE      = 2'd3;

  localparam logic [AmpW-1:0]  AMP_RST   = 15'd30000;
  localparam logic [PerW-1:0]  PER_RST   = 24'd1365;
  localparam logic [PosW-1:0]  TOTAL_RST = 20'd24000;
  localparam logic [FadeW-1:0] FADE_RST  = 16'd80;

  typedef struct packed {
    logic                 start;
    logic [DividendW-1:0] dividend;
    logic [DivisorW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DividendW-1:0] quotient;
    logic [DivisorW-1:0]  remainder;
  } div_rsp_t;

endpackage

// ===== design/stbf_div.sv =====
// ----------------------------------------------------------------------------
// stbf_div
// Restoring divider, one quotient bit per cycle, shared by all divides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stbf_div
  import stbf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DivisorW-1:0]  rem_q;
  logic [DividendW-1:0] quo_q;
  logic [DivisorW-1:0]  dvs_q;
  logic [StepCntW-1:0]  cnt_q;
  logic                 busy_q;
  logic                 done_q;

  logic [DivisorW:0]    trial;
  logic                 fits;
  logic [DivisorW:0]    diff;

  assign trial = {rem_q, quo_q[DividendW-1]};
  assign fits  = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        rem_q  <= '0;
        quo_q  <= req_i.dividend;
        dvs_q  <= req_i.divisor;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= fits ? diff[DivisorW-1:0] : trial[DivisorW-1:0];
        quo_q <= {quo_q[DividendW-2:0], fits};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == StepCntW'(DividendW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

// ===== design/square_tone_burst_with_fade.sv =====
// ----------------------------------------------------------------------------
// square_tone_burst_with_fade
// Renders a run of a square-wave alert burst with linear fade-in/fade-out.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid_i/in_ready_o) carries start_index and
//   sample_budget. The block emits min(budget, MAX_CHUNK, total - start)
//   samples on the sample channel (out_valid_o/out_ready_i), the final one
//   flagged by last_of_run_o. A request that yields no sample is dropped.
//   in_ready_o is high only between requests.
//   Sequencing: one shared 32-step divider serves every divide. A request
//   runs the start-phase divide, then the phase-step divide (skipped when
//   period is zero), then amplitude/fade (skipped when fade is zero), then
//   emits one sample per cycle unless the receiver stalls, with another
//   divide whenever a ramp restarts (at most twice per run).
//   A stalled receiver holds the output register; generation pauses until
//   the pending transfer completes. Reset loads the default register
//   values and returns to idle. Registers are written through
//   cfg_we_i/cfg_idx_i/cfg_data_i by the user only while idle; not enforced.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module square_tone_burst_with_fade
  import stbf_pkg::*;
#(
  parameter int unsigned MAX_CHUNK = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [PerW-1:0]      cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [PosW-1:0]      start_index_i,
  input  logic [BudW-1:0]      sample_budget_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [SmpW-1:0] sample_value_o,
  output logic [PosW-1:0]      sample_position_o,
  output logic                 last_of_run_o
);

  localparam int unsigned CntW = $clog2(MAX_CHUNK + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PHASE,
    S_STEP,
    S_ADIV,
    S_SAMPLE,
    S_MDIV
  } state_e;

  // registers
  logic [AmpW-1:0]  amp_q;
  logic [PerW-1:0]  per_q;
  logic [PosW-1:0]  tot_q;
  logic [FadeW-1:0] fade_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_q  <= AMP_RST;
      per_q  <= PER_RST;
      tot_q  <= TOTAL_RST;
      fade_q <= FADE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_AMPLITUDE: amp_q  <= cfg_data_i[AmpW-1:0];
        REG_PERIOD:    per_q  <= cfg_data_i[PerW-1:0];
        REG_TOTAL:     tot_q  <= cfg_data_i[PosW-1:0];
        REG_FADE:      fade_q <= cfg_data_i[FadeW-1:0];
        default:       ;
      endcase
    end
  end

  state_e           state_q;
  logic             issued_q;
  logic [PosW-1:0]  pos_q;
  logic [CntW-1:0]  cnt_q;
  logic [PerW-1:0]  phase_q;
  logic [PerW-1:0]  step_q;
  logic [AmpW-1:0]  qs_q;
  logic [FadeW-1:0] rs_q;
  logic [AmpW-1:0]  q_q;
  logic [FadeW-1:0] r_q;
  logic [FadeW-1:0] kp_q;
  logic             have_k_q;
  logic             out_valid_q;
  logic [SmpW-1:0]  value_q;
  logic [PosW-1:0]  position_q;
  logic             last_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  stbf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // request decode
  logic            in_acc;
  logic [BudW-1:0] bud_sat;
  logic [PosW-1:0] left;
  logic [CntW-1:0] n_req;
  logic            n_nz;
  logic            per_zero;
  logic            fade_on;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign per_zero   = (per_q == '0);
  assign fade_on    = (fade_q != '0);
  assign bud_sat    = (sample_budget_i > BudW'(MAX_CHUNK)) ? BudW'(MAX_CHUNK)
                                                           : sample_budget_i;
  assign left       = tot_q - start_index_i;
  assign n_nz       = (start_index_i < tot_q) && (bud_sat != '0);
  assign n_req      = (left < PosW'(bud_sat)) ? left[CntW-1:0] : bud_sat[CntW-1:0];

  // fade ramp tracking
  logic [PosW-1:0]  to_end;
  logic             ramp_in;
  logic             ramp_out;
  logic             ramp;
  logic [FadeW-1:0] k;
  logic             k_same;
  logic             k_up;
  logic             k_dn;
  logic             reseed;
  logic [FadeW:0]   r_add;
  logic             add_wrap;
  logic [FadeW:0]   r_sub_wrap;
  logic             sub_wrap;
  logic [AmpW-1:0]  q_n;
  logic [FadeW-1:0] r_n;
  logic [AmpW-1:0]  mag;
  logic [AmpW+FadeW-1:0] mag_prod;

  assign to_end   = tot_q - pos_q;
  assign ramp_in  = pos_q < PosW'(fade_q);
  assign ramp_out = to_end < PosW'(fade_q);
  assign ramp     = fade_on && (ramp_in || ramp_out);
  assign k        = ramp_in ? pos_q[FadeW-1:0] : to_end[FadeW-1:0];
  assign k_same   = have_k_q && (k == kp_q);
  assign k_up     = have_k_q && (k == kp_q + 1'b1);
  assign k_dn     = have_k_q && (kp_q != '0) && (k == kp_q - 1'b1);
  assign reseed   = ramp && !(k_same || k_up || k_dn);

  assign r_add      = {1'b0, r_q} + {1'b0, rs_q};
  assign add_wrap   = r_add >= {1'b0, fade_q};
  assign sub_wrap   = r_q < rs_q;
  assign r_sub_wrap = {1'b0, r_q} + {1'b0, fade_q} - {1'b0, rs_q};

  always_comb begin
    q_n = q_q;
    r_n = r_q;
    if (k_up) begin
      if (add_wrap) begin
        q_n = q_q + qs_q + 1'b1;
        r_n = FadeW'(r_add - {1'b0, fade_q});
      end else begin
        q_n = q_q + qs_q;
        r_n = r_add[FadeW-1:0];
      end
    end else if (k_dn) begin
      if (sub_wrap) begin
        q_n = q_q - qs_q - 1'b1;
        r_n = r_sub_wrap[FadeW-1:0];
      end else begin
        q_n = q_q - qs_q;
        r_n = r_q - rs_q;
      end
    end
  end

  assign mag      = ramp ? q_n : amp_q;
  assign mag_prod = amp_q * kp_q;

  // tone phase
  logic          high;
  logic [PerW:0] ph_sum;
  logic [PerW-1:0] ph_next;

  assign high    = per_zero || (phase_q < (per_q >> 1));
  assign ph_sum  = {1'b0, phase_q} + {1'b0, step_q};
  assign ph_next = (ph_sum >= {1'b0, per_q}) ? PerW'(ph_sum - {1'b0, per_q})
                                             : ph_sum[PerW-1:0];

  logic            out_free;
  logic            emit;
  logic [SmpW-1:0] mag_ext;

  assign out_free = !out_valid_q || out_ready_i;
  assign emit     = (state_q == S_SAMPLE) && !reseed && out_free;
  assign mag_ext  = {1'b0, mag};

  // divider operands
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = per_q;
    case (state_q)
      S_PHASE: begin
        div_req.start    = !issued_q;
        div_req.dividend = DividendW'({pos_q, 8'd0});
      end
      S_STEP: begin
        div_req.start    = !issued_q;
        div_req.dividend = DividendW'(256);
      end
      S_ADIV: begin
        div_req.start    = !issued_q;
        div_req.dividend = DividendW'(amp_q);
        div_req.divisor  = DivisorW'(fade_q);
      end
      S_MDIV: begin
        div_req.start    = !issued_q;
        div_req.dividend = DividendW'(mag_prod);
        div_req.divisor  = DivisorW'(fade_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issued_q    <= 1'b0;
      pos_q       <= '0;
      cnt_q       <= '0;
      phase_q     <= '0;
      step_q      <= '0;
      qs_q        <= '0;
      rs_q        <= '0;
      q_q         <= '0;
      r_q         <= '0;
      kp_q        <= '0;
      have_k_q    <= 1'b0;
      out_valid_q <= 1'b0;
      value_q     <= '0;
      position_q  <= '0;
      last_q      <= 1'b0;
    end else begin
      if (div_req.start) begin
        issued_q <= 1'b1;
      end
      if (div_rsp.done) begin
        issued_q <= 1'b0;
      end

      if (emit) begin
        out_valid_q <= 1'b1;
        value_q     <= high ? mag_ext : -mag_ext;
        position_q  <= pos_q;
        last_q      <= (cnt_q == CntW'(1));
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc && n_nz) begin
            pos_q    <= start_index_i;
            cnt_q    <= n_req;
            have_k_q <= 1'b0;
            if (!per_zero) begin
              state_q <= S_PHASE;
            end else if (fade_on) begin
              state_q <= S_ADIV;
            end else begin
              state_q <= S_SAMPLE;
            end
          end
        end
        S_PHASE: begin
          if (div_rsp.done) begin
            phase_q <= div_rsp.remainder;
            state_q <= S_STEP;
          end
        end
        S_STEP: begin
          if (div_rsp.done) begin
            step_q  <= div_rsp.remainder;
            state_q <= fade_on ? S_ADIV : S_SAMPLE;
          end
        end
        S_ADIV: begin
          if (div_rsp.done) begin
            qs_q    <= div_rsp.quotient[AmpW-1:0];
            rs_q    <= div_rsp.remainder[FadeW-1:0];
            state_q <= S_SAMPLE;
          end
        end
        S_MDIV: begin
          if (div_rsp.done) begin
            q_q      <= div_rsp.quotient[AmpW-1:0];
            r_q      <= div_rsp.remainder[FadeW-1:0];
            have_k_q <= 1'b1;
            state_q  <= S_SAMPLE;
          end
        end
        S_SAMPLE: begin
          if (reseed) begin
            kp_q    <= k;
            state_q <= S_MDIV;
          end else if (out_free) begin
            if (ramp) begin
              q_q  <= q_n;
              r_q  <= r_n;
              kp_q <= k;
            end
            phase_q <= ph_next;
            pos_q   <= pos_q + 1'b1;
            cnt_q   <= cnt_q - 1'b1;
            if (cnt_q == CntW'(1)) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign sample_value_o    = value_q;
  assign sample_position_o = position_q;
  assign last_of_run_o     = last_q;

`include "square_tone_burst_with_fade_defines.svh"

  `STBF_ASSERT_IMP(a_idle_no_count, state_q == S_IDLE, cnt_q == '0, "idle with samples left")
  `STBF_ASSERT_IMP(a_div_free, div_req.start, !div_rsp.busy, "divider restarted while busy")
  `STBF_ASSERT_IMP(a_div_nonzero, div_req.start, div_req.divisor != '0, "divide by zero issued")
  `STBF_ASSERT_NXT(a_last_ends, emit && (cnt_q == CntW'(1)), state_q == S_IDLE, "run did not end")

endmodule

// ===== tb/square_tone_burst_with_fade_test.sv =====
// ----------------------------------------------------------------------------
// square_tone_burst_with_fade_test
// Self-checking bench for the square tone burst renderer. Render requests
// go in through a valid/ready driver fed from a planned list. Register
// writes happen only once the block has gone quiet. Every sample transfer
// is checked against a local model of the faded square wave. Random idle
// gaps and receiver stalls are applied. Directed corner requests come
// first, then randomized register sets with mostly in-range requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module square_tone_burst_with_fade_test;
  import stbf_pkg::*;

  localparam int unsigned ClkPeriod    = 10;
  localparam int unsigned SampleCap    = 64;
  localparam int unsigned SettleCycles = 300;
  localparam int unsigned CycleLimit   = 1000000;

  typedef enum logic [1:0] {OP_REQ, OP_CFG, OP_DRAIN} plan_kind_e;

  typedef struct {
    plan_kind_e          kind;
    logic [PosW-1:0]     start;
    logic [BudW-1:0]     budget;
    logic [CfgIdxW-1:0]  reg_idx;
    logic [PerW-1:0]     data;
    int unsigned         gap;
  } plan_entry_t;

  typedef struct {
    logic signed [SmpW-1:0] value;
    logic [PosW-1:0]        pos;
    logic                   last;
  } tone_sample_t;

  logic                   clk_i           = 1'b0;
  logic                   rst_ni          = 1'b0;
  logic                   cfg_we_i        = 1'b0;
  logic [CfgIdxW-1:0]     cfg_idx_i       = '0;
  logic [PerW-1:0]        cfg_data_i      = '0;
  logic                   in_valid_i      = 1'b0;
  logic                   in_ready_o;
  logic [PosW-1:0]        start_index_i   = '0;
  logic [BudW-1:0]        sample_budget_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i     = 1'b0;
  logic signed [SmpW-1:0] sample_value_o;
  logic [PosW-1:0]        sample_position_o;
  logic                   last_of_run_o;

  // register copies used by the predictor
  logic [AmpW-1:0]  amp_q    = AMP_RST;
  logic [PerW-1:0]  period_q = PER_RST;
  logic [PosW-1:0]  total_q  = TOTAL_RST;
  logic [FadeW-1:0] fade_q   = FADE_RST;

  // register values as planned, used to shape requests
  int unsigned plan_total = TOTAL_RST;
  int unsigned plan_fade  = FADE_RST;
  bit          plan_calm  = 1'b0;

  plan_entry_t  request_plan[$];
  tone_sample_t pending_samples[$];
  tone_sample_t want;

  logic        req_fire     = 1'b0;
  int unsigned gap_left     = 0;
  int unsigned rx_hold      = 0;
  int unsigned rx_pick;
  int unsigned quiet_cycles = 0;
  int unsigned cycle_count  = 0;
  int unsigned mismatches   = 0;

  square_tone_burst_with_fade #(
    .MAX_CHUNK(SampleCap)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .start_index_i,
    .sample_budget_i,
    .out_valid_o,
    .out_ready_i,
    .sample_value_o,
    .sample_position_o,
    .last_of_run_o
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // faded square-wave level at one burst index
  function automatic logic signed [SmpW-1:0] tone_level(input logic [PosW-1:0] idx);
    longint unsigned phase;
    longint unsigned mag;
    logic [31:0] to_end;
    logic high;
    logic signed [SmpW-1:0] level;
    high = 1'b1;
    if (period_q != '0) begin
      phase = {36'd0, idx, 8'd0};
      phase = phase % period_q;
      high  = phase < (period_q >> 1);
    end
    mag    = amp_q;
    to_end = 32'(total_q) - 32'(idx);
    if (fade_q != '0) begin
      if (idx < fade_q) begin
        mag = (mag * idx) / fade_q;
      end else if (to_end < fade_q) begin
        mag = (mag * to_end) / fade_q;
      end
    end
    level = mag[SmpW-1:0];
    return high ? level : -level;
  endfunction

  // queue the samples one request yields
  function automatic void render_run(input logic [PosW-1:0] start,
                                     input logic [BudW-1:0] budget);
    int unsigned count;
    int unsigned room;
    tone_sample_t s;
    count = (budget > SampleCap) ? SampleCap : budget;
    if (start >= total_q) begin
      count = 0;
    end else begin
      room = total_q - start;
      if (room < count) count = room;
    end
    for (int unsigned i = 0; i < count; i++) begin
      s.pos   = PosW'(start + i);
      s.value = tone_level(s.pos);
      s.last  = (i + 1 == count);
      pending_samples.push_back(s);
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (plan_calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [PosW-1:0] pick_start();
    int unsigned r;
    int unsigned span;
    r = $urandom_range(0, 99);
    if (plan_total == 0 || r >= 92) return PosW'($urandom());
    span = (plan_total < 100) ? plan_total : 100;
    if (r < 25) return PosW'($urandom_range(0, span - 1));
    if (r < 50) return PosW'(plan_total - $urandom_range(1, span));
    if (r < 62 && plan_fade != 0) return PosW'(plan_fade + $urandom_range(0, 8) - 4);
    if (r < 85) return PosW'($urandom_range(0, plan_total - 1));
    return PosW'(plan_total + $urandom_range(0, 3));
  endfunction

  function automatic logic [BudW-1:0] pick_budget();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return BudW'($urandom_range(1, 64));
    if (r < 75) return BudW'(SampleCap);
    if (r < 85) return BudW'($urandom_range(65, 127));
    if (r < 90) return '0;
    return BudW'($urandom_range(1, 8));
  endfunction

  task automatic push_req(input logic [PosW-1:0] start, input logic [BudW-1:0] budget);
    plan_entry_t e;
    e.kind    = OP_REQ;
    e.start   = start;
    e.budget  = budget;
    e.reg_idx = '0;
    e.data    = '0;
    e.gap     = pick_gap();
    request_plan.push_back(e);
  endtask

  task automatic push_cfg(input logic [CfgIdxW-1:0] reg_idx, input logic [PerW-1:0] data);
    plan_entry_t e;
    e.kind    = OP_CFG;
    e.start   = '0;
    e.budget  = '0;
    e.reg_idx = reg_idx;
    e.data    = data;
    e.gap     = 0;
    request_plan.push_back(e);
    if (reg_idx == REG_TOTAL) plan_total = data[PosW-1:0];
    if (reg_idx == REG_FADE)  plan_fade  = data[FadeW-1:0];
  endtask

  task automatic push_drain();
    plan_entry_t e;
    e.kind    = OP_DRAIN;
    e.start   = '0;
    e.budget  = '0;
    e.reg_idx = '0;
    e.data    = '0;
    e.gap     = 0;
    request_plan.push_back(e);
  endtask

  task automatic push_random_regs(input int unsigned phase_no);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (phase_no == 1)  push_cfg(REG_TOTAL, 24'hFFFFF);
    else if (r < 8)     push_cfg(REG_TOTAL, '0);
    else if (r < 70)    push_cfg(REG_TOTAL, PerW'($urandom_range(1, 3000)));
    else if (r < 85)    push_cfg(REG_TOTAL, PerW'($urandom_range(3000, 24'hFFFFF)));
    else if (r < 90)    push_cfg(REG_TOTAL, 24'hFFFFF);
    else                push_cfg(REG_TOTAL, PerW'($urandom_range(1, 64)));
    r = $urandom_range(0, 99);
    if (r < 20)         push_cfg(REG_FADE, '0);
    else if (r < 60)    push_cfg(REG_FADE, PerW'($urandom_range(1, 200)));
    else if (r < 75)    push_cfg(REG_FADE, PerW'($urandom_range(1, 65535)));
    else if (r < 85)    push_cfg(REG_FADE, 24'hFFFF);
    else                push_cfg(REG_FADE, PerW'(plan_total + $urandom_range(0, 50)));
    r = $urandom_range(0, 99);
    if (r < 10)         push_cfg(REG_PERIOD, 24'd2);
    else if (r < 15)    push_cfg(REG_PERIOD, '0);
    else if (r < 20)    push_cfg(REG_PERIOD, 24'd1);
    else if (r < 30)    push_cfg(REG_PERIOD, 24'hFFFFFF);
    else if (r < 70)    push_cfg(REG_PERIOD, PerW'($urandom_range(2, 4000)));
    else                push_cfg(REG_PERIOD, PerW'($urandom_range(2, 24'hFFFFFF)));
    r = $urandom_range(0, 99);
    if (r < 20)         push_cfg(REG_AMPLITUDE, 24'h7FFF);
    else if (r < 28)    push_cfg(REG_AMPLITUDE, '0);
    else if (r < 40)    push_cfg(REG_AMPLITUDE, PerW'($urandom()));
    else                push_cfg(REG_AMPLITUDE, PerW'($urandom_range(0, 32767)));
  endtask

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        cfg_we_i <= 1'b0;
      end else if (!in_valid_i || req_fire) begin
        if (gap_left != 0) begin
          in_valid_i <= 1'b0;
          gap_left   <= gap_left - 1;
        end else if (request_plan.size() != 0 && request_plan[0].kind == OP_REQ) begin
          in_valid_i      <= 1'b1;
          start_index_i   <= request_plan[0].start;
          sample_budget_i <= request_plan[0].budget;
          gap_left        <= request_plan[0].gap;
          request_plan.delete(0);
        end else begin
          in_valid_i <= 1'b0;
          if (request_plan.size() != 0) begin
            case (request_plan[0].kind)
              OP_CFG: begin
                if (quiet_cycles >= SettleCycles) begin
                  cfg_we_i   <= 1'b1;
                  cfg_idx_i  <= request_plan[0].reg_idx;
                  cfg_data_i <= request_plan[0].data;
                  request_plan.delete(0);
                end
              end
              OP_DRAIN: begin
                if (pending_samples.size() == 0) request_plan.delete(0);
              end
              default: begin
              end
            endcase
          end
        end
      end
    end
  end

  // sample receiver backpressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_hold != 0) begin
        rx_hold <= rx_hold - 1;
      end else begin
        rx_pick = $urandom_range(0, 99);
        if (rx_pick < 4) begin
          out_ready_i <= 1'b1;
          rx_hold     <= $urandom_range(200, 600);
        end else if (rx_pick < 55) begin
          out_ready_i <= 1'b1;
          rx_hold     <= $urandom_range(0, 12);
        end else if (rx_pick < 92) begin
          out_ready_i <= 1'b0;
          rx_hold     <= $urandom_range(0, 3);
        end else begin
          out_ready_i <= 1'b0;
          rx_hold     <= $urandom_range(8, 20);
        end
      end
    end
  end

  // monitor: register writes, request transfers, sample checks
  always @(posedge clk_i) begin
    if (rst_ni) begin
      req_fire <= in_valid_i && in_ready_o;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_AMPLITUDE: amp_q    = cfg_data_i[AmpW-1:0];
          REG_PERIOD:    period_q = cfg_data_i[PerW-1:0];
          REG_TOTAL:     total_q  = cfg_data_i[PosW-1:0];
          REG_FADE:      fade_q   = cfg_data_i[FadeW-1:0];
          default: begin
          end
        endcase
      end
      if (in_valid_i && in_ready_o) render_run(start_index_i, sample_budget_i);
      if (out_valid_o && out_ready_i) begin
        if (pending_samples.size() == 0) begin
          $display("%0t: expected no sample, actual value %0d position %0d last %0b",
                   $time, sample_value_o, sample_position_o, last_of_run_o);
          mismatches++;
        end else begin
          want = pending_samples.pop_front();
          if (sample_value_o !== want.value) begin
            $display("%0t: sample_value expected %0d actual %0d", $time,
                     want.value, sample_value_o);
            mismatches++;
          end
          if (sample_position_o !== want.pos) begin
            $display("%0t: sample_position expected %0d actual %0d", $time,
                     want.pos, sample_position_o);
            mismatches++;
          end
          if (last_of_run_o !== want.last) begin
            $display("%0t: last_of_run expected %0b actual %0b", $time,
                     want.last, last_of_run_o);
            mismatches++;
          end
        end
      end
      if (pending_samples.size() == 0 && !in_valid_i && in_ready_o && !out_valid_o) begin
        if (quiet_cycles < SettleCycles) quiet_cycles <= quiet_cycles + 1;
      end else begin
        quiet_cycles <= 0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    // reset register values
    push_req(20'd0, 7'd64);
    push_req(20'd40, 7'd127);
    push_req(20'd23990, 7'd64);
    push_req(20'd23999, 7'd1);
    push_req(20'd24000, 7'd5);
    push_req(20'hFFFFF, 7'd127);
    push_req(20'd100, 7'd0);
    push_req(20'd1000, 7'd65);
    // full amplitude via an over-wide write, period two, no fade
    push_cfg(REG_AMPLITUDE, 24'hFFFFFF);
    push_cfg(REG_PERIOD, 24'd2);
    push_cfg(REG_TOTAL, 24'hFFFFF);
    push_cfg(REG_FADE, '0);
    push_req(20'hFFFF0, 7'd64);
    push_req(20'hAAAAA, 7'd64);
    push_req(20'h55555, 7'd42);
    // zero period: always high; longest fade
    push_cfg(REG_PERIOD, '0);
    push_cfg(REG_TOTAL, 24'd100000);
    push_cfg(REG_FADE, 24'hFFFF);
    push_req(20'd65500, 7'd64);
    push_req(20'd99930, 7'd64);
    // period one: always low; short burst
    push_cfg(REG_PERIOD, 24'd1);
    push_cfg(REG_AMPLITUDE, 24'd12345);
    push_cfg(REG_TOTAL, 24'd10);
    push_cfg(REG_FADE, 24'd4);
    push_req(20'd0, 7'd64);
    push_req(20'd9, 7'd3);
    push_drain();
    // empty burst; upper data bits dropped
    push_cfg(REG_TOTAL, 24'hF00000);
    push_cfg(REG_FADE, 24'hFF0000);
    push_req(20'd0, 7'd64);
    push_req(20'd0, 7'd1);
    // fade longer than the burst, longest period, silent then loud
    push_cfg(REG_TOTAL, 24'd256);
    push_cfg(REG_FADE, 24'd300);
    push_cfg(REG_PERIOD, 24'hFFFFFF);
    push_cfg(REG_AMPLITUDE, '0);
    push_req(20'd0, 7'd64);
    push_req(20'd200, 7'd64);
    push_cfg(REG_AMPLITUDE, 24'h7FFF);
    push_req(20'd100, 7'd64);

    for (int unsigned p = 0; p < 7; p++) begin
      plan_calm = (p == 2);
      push_random_regs(p);
      for (int unsigned k = 0; k < 16; k++) begin
        if (p == 3 && k == 10) push_drain();
        push_req(pick_start(), pick_budget());
      end
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (request_plan.size() != 0 || in_valid_i || cfg_we_i) @(posedge clk_i);
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
